// ===== rtl/lge_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lge_pkg
// Shared constants, types and state codes for the life generation engine.
// ============================================================================
package lge_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int SIZE_W   = 7;
    localparam int FUNC_W   = 2;
    localparam int CNT_W    = 4;
    localparam int GEN_W    = 32;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // B3/S23 rule counts
    localparam logic [CNT_W-1:0] CNT_BIRTH = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_KEEP  = CNT_W'(2);

    // register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE  = 2'd0,
        FN_READ   = 2'd1,
        FN_EVOLVE = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    typedef logic [MAX_COLS-1:0] row_bits_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
        row_bits_t        wr_data;
        logic             clear;
    } mem_req_t;

    typedef struct packed {
        logic [SIZE_W-1:0] rows_used;
        logic [SIZE_W-1:0] cols_used;
        logic              wipe;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WR_RD,
        S_WR_WB,
        S_LD_PREV,
        S_LD_CUR,
        S_LD_NEXT,
        S_LD_DONE,
        S_COUNT,
        S_SWEEP,
        S_ROW_WR,
        S_SHIFT,
        S_FINISH
    } state_t;

endpackage

// ===== rtl/lge_cmd_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lge_cmd_if
// Command channel: one beat carries func, row, col and alive_in.
// ============================================================================
interface lge_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [lge_pkg::FUNC_W-1:0] func;
    logic [lge_pkg::ROW_W-1:0]  row;
    logic [lge_pkg::COL_W-1:0]  col;
    logic                       alive_in;

    modport source (output valid, output func, output row, output col, output alive_in,
                    input ready);
    modport sink   (input valid, input func, input row, input col, input alive_in,
                    output ready);
endinterface

// ===== rtl/lge_rsp_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lge_rsp_if
// Response channel: one beat carries alive_out, neighbour_count, generation.
// ============================================================================
interface lge_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      alive_out;
    logic [lge_pkg::CNT_W-1:0] neighbour_count;
    logic [lge_pkg::GEN_W-1:0] generation;

    modport source (output valid, output alive_out, output neighbour_count,
                    output generation, input ready);
    modport sink   (input valid, input alive_out, input neighbour_count,
                    input generation, output ready);
endinterface

// ===== rtl/lge_apb_regs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lge_apb_regs
// APB register file for the grid size; clamps sizes and flags a wipe on write.
// ============================================================================
module lge_apb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lge_pkg::APB_AW-1:0] paddr,
    input  logic [lge_pkg::APB_DW-1:0] pwdata,
    output logic [lge_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output lge_pkg::cfg_t              cfg
);
    import lge_pkg::*;

    logic [SIZE_W-1:0] row_count_reg;
    logic [SIZE_W-1:0] col_count_reg;
    logic              wr_hit;
    logic              reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1];
    assign wr_hit  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= SIZE_W'(MAX_ROWS);
            col_count_reg <= SIZE_W'(MAX_COLS);
        end
        else if (wr_hit)
        begin
            unique case (reg_idx)
                REG_ROW_COUNT: row_count_reg <= pwdata[SIZE_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[SIZE_W-1:0];
                default:       row_count_reg <= row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW_COUNT: prdata = APB_DW'(row_count_reg);
            REG_COL_COUNT: prdata = APB_DW'(col_count_reg);
            default:       prdata = '0;
        endcase
    end

    // zero counts as one, oversize saturates
    always_comb
    begin
        if (row_count_reg == '0)
            cfg.rows_used = SIZE_W'(1);
        else if (row_count_reg > SIZE_W'(MAX_ROWS))
            cfg.rows_used = SIZE_W'(MAX_ROWS);
        else
            cfg.rows_used = row_count_reg;

        if (col_count_reg == '0)
            cfg.cols_used = SIZE_W'(1);
        else if (col_count_reg > SIZE_W'(MAX_COLS))
            cfg.cols_used = SIZE_W'(MAX_COLS);
        else
            cfg.cols_used = col_count_reg;

        cfg.wipe = wr_hit;
    end

endmodule

// ===== rtl/lge_grid_mem.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lge_grid_mem
// Row-wide cell store with per-row valid bits; invalid rows read as dead.
// ============================================================================
module lge_grid_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  lge_pkg::mem_req_t  req,
    output lge_pkg::row_bits_t rd_data
);
    import lge_pkg::*;

    row_bits_t            cell_mem_reg [MAX_ROWS];
    logic [MAX_ROWS-1:0]  row_valid_reg;
    row_bits_t            rd_raw_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            cell_mem_reg[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
            rd_raw_reg <= cell_mem_reg[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.clear)
                row_valid_reg <= '0;
            else if (req.wr_en)
                row_valid_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en)
                rd_valid_reg <= row_valid_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

// ===== rtl/lge_nbr_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lge_nbr_unit
// Shared neighbour counter: wrapped eight-cell count and B3/S23 next state.
// ============================================================================
module lge_nbr_unit (
    input  lge_pkg::row_bits_t          row_up,
    input  lge_pkg::row_bits_t          row_mid,
    input  lge_pkg::row_bits_t          row_dn,
    input  logic [lge_pkg::COL_W-1:0]   col,
    input  logic [lge_pkg::SIZE_W-1:0]  cols_used,
    output logic [lge_pkg::CNT_W-1:0]   count,
    output logic                        alive_next
);
    import lge_pkg::*;

    logic [COL_W-1:0]  col_l;
    logic [COL_W-1:0]  col_r;
    logic [SIZE_W-1:0] cols_m1;

    assign cols_m1 = cols_used - SIZE_W'(1);
    assign col_l   = (col == '0) ? cols_m1[COL_W-1:0] : col - COL_W'(1);
    assign col_r   = (SIZE_W'(col) + SIZE_W'(1) == cols_used) ? '0 : col + COL_W'(1);

    assign count = CNT_W'(row_up[col_l])  + CNT_W'(row_up[col])  + CNT_W'(row_up[col_r])
                 + CNT_W'(row_mid[col_l]) + CNT_W'(row_mid[col_r])
                 + CNT_W'(row_dn[col_l])  + CNT_W'(row_dn[col])  + CNT_W'(row_dn[col_r]);

    always_comb
    begin
        case (count)
            CNT_BIRTH: alive_next = 1'b1;
            CNT_KEEP:  alive_next = row_mid[col];
            default:   alive_next = 1'b0;
        endcase
    end

endmodule

// ===== rtl/life_generation_engine_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// life_generation_engine_core
// Toroidal B3/S23 life grid with cell write/read, clear and evolve commands.
// ============================================================================
// Every command beat returns exactly one response beat. The grid sits in a
// row-wide memory (one 64-bit word per row) with a valid bit per row, so
// reset, clear and a size write take effect at once, with no sweep. While a
// command is in work cmd.ready is low; a finished response waits in an
// output register, so the next command is taken even if rsp is stalled.
// A clear acts at the accept; a write is a read-modify-write of one row; a
// read makes three row fetches, then one count. Evolve uses a single
// neighbour counter that sweeps the columns of each row one cell per clock,
// plus row fetch and write-back.
// A stalled rsp holds a finished command until its output register frees.
// Rows are updated in place; row 0 is saved before it is overwritten so
// the last row still sees the old top row across the wrap.
// Writing row_count or col_count wipes the grid and zeroes the generation.
module life_generation_engine_core (
    input  logic                       clk,
    input  logic                       rst_n,
    lge_cmd_if.sink                    cmd,
    lge_rsp_if.source                  rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lge_pkg::APB_AW-1:0] paddr,
    input  logic [lge_pkg::APB_DW-1:0] pwdata,
    output logic [lge_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import lge_pkg::*;

    cfg_t      cfg;
    mem_req_t  mem_req;
    row_bits_t mem_rd;

    state_t state_reg, state_next;

    // command fields
    func_t            func_reg,  func_next;
    logic [ROW_W-1:0] row_reg,   row_next;
    logic [COL_W-1:0] col_reg,   col_next;
    logic             alive_reg, alive_next;

    // row window: up = r-1, mid = r, dn = r+1 (wrapped); top = saved row 0
    row_bits_t row_up_reg,  row_up_next;
    row_bits_t row_mid_reg, row_mid_next;
    row_bits_t row_dn_reg,  row_dn_next;
    row_bits_t row_top_reg, row_top_next;
    row_bits_t row_new_reg, row_new_next;

    logic             res_alive_reg, res_alive_next;
    logic [CNT_W-1:0] res_cnt_reg,   res_cnt_next;
    logic [GEN_W-1:0] gen_reg,       gen_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_alive_reg, out_alive_next;
    logic [CNT_W-1:0] out_cnt_reg,   out_cnt_next;
    logic [GEN_W-1:0] out_gen_reg,   out_gen_next;

    logic [SIZE_W-1:0] rows_m1;
    logic [ROW_W-1:0]  row_up_idx;
    logic [ROW_W-1:0]  row_dn_idx;
    logic              row_last;
    logic              col_last;
    logic              cmd_inside;
    logic [CNT_W-1:0]  nbr_cnt;
    logic              nbr_alive;
    row_bits_t         wb_row;

    lge_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lge_grid_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (mem_rd)
    );

    lge_nbr_unit u_nbr (
        .row_up     (row_up_reg),
        .row_mid    (row_mid_reg),
        .row_dn     (row_dn_reg),
        .col        (col_reg),
        .cols_used  (cfg.cols_used),
        .count      (nbr_cnt),
        .alive_next (nbr_alive)
    );

    // wrapped row neighbours of row_reg
    assign rows_m1    = cfg.rows_used - SIZE_W'(1);
    assign row_up_idx = (row_reg == '0) ? rows_m1[ROW_W-1:0] : row_reg - ROW_W'(1);
    assign row_last   = (SIZE_W'(row_reg) + SIZE_W'(1) == cfg.rows_used);
    assign row_dn_idx = row_last ? '0 : row_reg + ROW_W'(1);
    assign col_last   = (SIZE_W'(col_reg) + SIZE_W'(1) == cfg.cols_used);
    assign cmd_inside = (SIZE_W'(cmd.row) < cfg.rows_used) &&
                        (SIZE_W'(cmd.col) < cfg.cols_used);

    assign cmd.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.alive_out       = out_alive_reg;
    assign rsp.neighbour_count = out_cnt_reg;
    assign rsp.generation      = out_gen_reg;

    always_comb
    begin
        wb_row          = mem_rd;
        wb_row[col_reg] = alive_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        alive_reg     <= alive_next;
        row_up_reg    <= row_up_next;
        row_mid_reg   <= row_mid_next;
        row_dn_reg    <= row_dn_next;
        row_top_reg   <= row_top_next;
        row_new_reg   <= row_new_next;
        res_alive_reg <= res_alive_next;
        res_cnt_reg   <= res_cnt_next;
        out_alive_reg <= out_alive_next;
        out_cnt_reg   <= out_cnt_next;
        out_gen_reg   <= out_gen_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        alive_next     = alive_reg;
        row_up_next    = row_up_reg;
        row_mid_next   = row_mid_reg;
        row_dn_next    = row_dn_reg;
        row_top_next   = row_top_reg;
        row_new_next   = row_new_reg;
        res_alive_next = res_alive_reg;
        res_cnt_next   = res_cnt_reg;
        gen_next       = gen_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        out_alive_next = out_alive_reg;
        out_cnt_next   = out_cnt_reg;
        out_gen_next   = out_gen_reg;
        mem_req        = '0;
        mem_req.clear  = cfg.wipe;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next      = func_t'(cmd.func);
                    row_next       = cmd.row;
                    col_next       = cmd.col;
                    alive_next     = cmd.alive_in;
                    res_alive_next = 1'b0;
                    res_cnt_next   = '0;
                    unique case (func_t'(cmd.func))
                        FN_WRITE:  state_next = cmd_inside ? S_WR_RD : S_FINISH;
                        FN_READ:   state_next = cmd_inside ? S_LD_PREV : S_FINISH;
                        FN_EVOLVE:
                        begin
                            row_next   = '0;
                            state_next = S_LD_PREV;
                        end
                        FN_CLEAR:
                        begin
                            mem_req.clear = 1'b1;
                            state_next    = S_FINISH;
                        end
                        default:   state_next = S_FINISH;
                    endcase
                end
            end

            S_WR_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = row_reg;
                state_next      = S_WR_WB;
            end

            S_WR_WB:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = row_reg;
                mem_req.wr_data = wb_row;
                state_next      = S_FINISH;
            end

            // fetch r-1, r, r+1 back to back; data lands in the cycle after each request
            S_LD_PREV:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = row_up_idx;
                state_next      = S_LD_CUR;
            end

            S_LD_CUR:
            begin
                row_up_next     = mem_rd;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = row_reg;
                state_next      = S_LD_NEXT;
            end

            S_LD_NEXT:
            begin
                row_mid_next    = mem_rd;
                row_top_next    = mem_rd;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = row_dn_idx;
                state_next      = S_LD_DONE;
            end

            S_LD_DONE:
            begin
                row_dn_next = mem_rd;
                if (func_reg == FN_READ)
                    state_next = S_COUNT;
                else
                begin
                    row_new_next = row_mid_reg;
                    col_next     = '0;
                    state_next   = S_SWEEP;
                end
            end

            S_COUNT:
            begin
                res_alive_next = row_mid_reg[col_reg];
                res_cnt_next   = nbr_cnt;
                state_next     = S_FINISH;
            end

            S_SWEEP:
            begin
                row_new_next[col_reg] = nbr_alive;
                if (col_last)
                    state_next = S_ROW_WR;
                else
                    col_next = col_reg + COL_W'(1);
            end

            S_ROW_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = row_reg;
                mem_req.wr_data = row_new_reg;
                if (row_last)
                begin
                    gen_next   = gen_reg + GEN_W'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    row_next   = row_reg + ROW_W'(1);
                    state_next = S_SHIFT;
                end
            end

            // slide the window down one row; bottom row wraps to saved row 0
            S_SHIFT:
            begin
                row_up_next  = row_mid_reg;
                row_mid_next = row_dn_reg;
                if (row_last)
                begin
                    row_dn_next  = row_top_reg;
                    row_new_next = row_dn_reg;
                    col_next     = '0;
                    state_next   = S_SWEEP;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = row_dn_idx;
                    state_next      = S_LD_DONE;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_alive_next = res_alive_reg;
                    out_cnt_next   = res_cnt_reg;
                    out_gen_next   = gen_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (cfg.wipe)
            gen_next = '0;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the toroidal B3/S23 life grid engine.
// Commands go in from a backlog through a clocked driver. A clocked monitor
// compares every response beat, field by field, against a cycle-free
// predictor of the grid that is updated at each command accept. Grid sizes
// are changed over the APB port between phases, only once the engine has
// drained. Both channels idle at random, and one receiver hold-off is long
// enough to back the engine up into its command input.
// ============================================================================
module testbench;
    import lge_pkg::*;

    localparam int IDLE_PCT    = 21;      // idle odds per cycle, in percent
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off
    localparam int TAIL_CYCLES = 60;      // quiet time after the last beat
    localparam int CYCLE_LIMIT = 600000;  // covers several slow full runs

    typedef struct packed {
        func_t            func;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             alive;
    } cmd_beat_t;

    typedef struct packed {
        logic             alive;
        logic [CNT_W-1:0] count;
        logic [GEN_W-1:0] gen;
    } rsp_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    lge_cmd_if cmd_ch ();
    lge_rsp_if rsp_ch ();

    // Commands waiting to be offered, and results owed by accepted commands.
    cmd_beat_t cmd_backlog [$];
    rsp_beat_t rsp_due [$];
    cmd_beat_t on_bus;
    rsp_beat_t want_rsp;

    // Predicted engine state: live grid, scratch for evolve, counter, sizes.
    bit                life_grid [MAX_ROWS][MAX_COLS];
    bit                grid_next [MAX_ROWS][MAX_COLS];
    logic [GEN_W-1:0]  gen_count;
    logic [SIZE_W-1:0] row_count_reg;
    logic [SIZE_W-1:0] col_count_reg;

    int fail_count     = 0;
    int stall_requests = 0;
    int stalls_served;
    int hold_left;
    int cycles_run;
    bit steady_run     = 1'b0;

    life_generation_engine_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Size registers are taken as 1 when zero and capped at the store size.
    function automatic int rows_in_use();
        if (row_count_reg == 0) return 1;
        if (row_count_reg > MAX_ROWS) return MAX_ROWS;
        return int'(row_count_reg);
    endfunction

    function automatic int cols_in_use();
        if (col_count_reg == 0) return 1;
        if (col_count_reg > MAX_COLS) return MAX_COLS;
        return int'(col_count_reg);
    endfunction

    function automatic void wipe_grid();
        foreach (life_grid[r, c]) life_grid[r][c] = 1'b0;
    endfunction

    // Offsets wrap modulo the size in use, so a cell on a one- or two-wide
    // grid may see itself, or one neighbor several times.
    function automatic logic [CNT_W-1:0] live_neighbours(int r, int c);
        int nr;
        int nc;
        int cnt;
        nr  = rows_in_use();
        nc  = cols_in_use();
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (dr != 0 || dc != 0)
                    cnt += life_grid[(r + nr + dr) % nr][(c + nc + dc) % nc];
            end
        end
        return CNT_W'(cnt);
    endfunction

    // B3/S23 from the old grid only, then one more generation.
    function automatic void evolve_grid();
        int nr;
        int nc;
        logic [CNT_W-1:0] n;
        nr = rows_in_use();
        nc = cols_in_use();
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                n = live_neighbours(r, c);
                if (n == CNT_BIRTH)
                    grid_next[r][c] = 1'b1;
                else if (n == CNT_KEEP)
                    grid_next[r][c] = life_grid[r][c];
                else
                    grid_next[r][c] = 1'b0;
            end
        end
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                life_grid[r][c] = grid_next[r][c];
        gen_count = gen_count + GEN_W'(1);
    endfunction

    // Applies one command to the predicted grid and returns its response.
    function automatic rsp_beat_t life_step(cmd_beat_t b);
        rsp_beat_t res;
        bit        in_grid;
        res     = '0;
        in_grid = (int'(b.row) < rows_in_use()) && (int'(b.col) < cols_in_use());
        case (b.func)
            FN_WRITE:
                if (in_grid) life_grid[b.row][b.col] = b.alive;
            FN_READ:
                if (in_grid)
                begin
                    res.alive = life_grid[b.row][b.col];
                    res.count = live_neighbours(int'(b.row), int'(b.col));
                end
            FN_EVOLVE:
                evolve_grid();
            default:
                wipe_grid();   // clear keeps the generation count
        endcase
        res.gen = gen_count;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: offers backlog items, predicts on every accepted beat.
    // valid stays up until the beat is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid    <= 1'b0;
            cmd_ch.func     <= FN_WRITE;
            cmd_ch.row      <= '0;
            cmd_ch.col      <= '0;
            cmd_ch.alive_in <= 1'b0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                rsp_due = {rsp_due, life_step(on_bus)};
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() != 0
                    && (steady_run || $urandom_range(99) >= IDLE_PCT))
                begin
                    on_bus           = cmd_backlog.pop_front();
                    cmd_ch.valid    <= 1'b1;
                    cmd_ch.func     <= on_bus.func;
                    cmd_ch.row      <= on_bus.row;
                    cmd_ch.col      <= on_bus.col;
                    cmd_ch.alive_in <= on_bus.alive;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor: checks each beat against the oldest expected result
    // and drives ready, including the long hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready  <= 1'b0;
            hold_left     <= 0;
            stalls_served <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response beat with no expected result pending");
                    fail_count++;
                end
                else
                begin
                    want_rsp = rsp_due.pop_front();
                    if (rsp_ch.alive_out !== want_rsp.alive)
                    begin
                        $error("alive_out: expected %0d, actual %0d",
                               want_rsp.alive, rsp_ch.alive_out);
                        fail_count++;
                    end
                    if (rsp_ch.neighbour_count !== want_rsp.count)
                    begin
                        $error("neighbour_count: expected %0d, actual %0d",
                               want_rsp.count, rsp_ch.neighbour_count);
                        fail_count++;
                    end
                    if (rsp_ch.generation !== want_rsp.gen)
                    begin
                        $error("generation: expected %0d, actual %0d",
                               want_rsp.gen, rsp_ch.generation);
                        fail_count++;
                    end
                end
            end
            if (stalls_served != stall_requests)
            begin
                stalls_served <= stall_requests;
                hold_left     <= HOLD_CYCLES;
                rsp_ch.ready  <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= steady_run || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_cmd(func_t f, int r, int c, bit a);
        cmd_beat_t b;
        b.func  = f;
        b.row   = ROW_W'(r);
        b.col   = COL_W'(c);
        b.alive = a;
        cmd_backlog = {cmd_backlog, b};
    endtask

    // Engine is idle once nothing is queued, offered or owed. Sampled on the
    // falling edge so that every update of the rising edge has settled.
    task automatic wait_drained();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_ch.valid || rsp_due.size() != 0)
            @(negedge clk);
    endtask

    // APB setup then access; the write lands on the access edge. Junk above
    // the 7-bit field must be dropped by the engine.
    task automatic write_size_reg(logic idx, logic [SIZE_W-1:0] value);
        logic [APB_DW-SIZE_W-1:0] junk;
        junk = (APB_DW-SIZE_W)'($urandom_range(32'h01FF_FFFF));
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // a size write starts a fresh, empty grid at generation zero
        if (idx == REG_ROW_COUNT)
            row_count_reg = value;
        else
            col_count_reg = value;
        wipe_grid();
        gen_count = '0;
    endtask

    task automatic set_grid_size(logic [SIZE_W-1:0] rows_raw, logic [SIZE_W-1:0] cols_raw);
        wait_drained();
        write_size_reg(REG_ROW_COUNT, rows_raw);
        write_size_reg(REG_COL_COUNT, cols_raw);
    endtask

    // Mostly well-formed work: seed a few live cells, evolve, read back.
    // Noise items hit any coordinate, inside the grid or not. Full-size
    // grids get at most two evolves since each one sweeps the whole store.
    task automatic random_phase(logic [SIZE_W-1:0] rows_raw, logic [SIZE_W-1:0] cols_raw,
                                int n);
        int    nr;
        int    nc;
        int    made;
        int    seeds;
        int    reads;
        int    evolves_left;
        bit    big;
        func_t f;
        set_grid_size(rows_raw, cols_raw);
        nr           = rows_in_use();
        nc           = cols_in_use();
        big          = (nr * nc > 1024);
        evolves_left = big ? 2 : n;
        made         = 0;
        while (made < n)
        begin
            seeds = $urandom_range(8, 2);
            for (int k = 0; k < seeds; k++)
                push_cmd(FN_WRITE, $urandom_range(nr - 1), $urandom_range(nc - 1),
                         $urandom_range(99) < 70);
            made += seeds;
            if (evolves_left > 0 && (!big || $urandom_range(99) < 40))
            begin
                push_cmd(FN_EVOLVE, $urandom_range(63), $urandom_range(63),
                         1'($urandom_range(1)));
                evolves_left--;
                made++;
            end
            reads = $urandom_range(4, 1);
            for (int k = 0; k < reads; k++)
                push_cmd(FN_READ, $urandom_range(nr - 1), $urandom_range(nc - 1),
                         1'($urandom_range(1)));
            made += reads;
            if ($urandom_range(99) < 30)
            begin
                f = func_t'($urandom_range(3));
                if (f == FN_EVOLVE && big)
                    f = FN_READ;
                push_cmd(f, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
                made++;
            end
            if ($urandom_range(99) < 6)
            begin
                push_cmd(FN_CLEAR, $urandom_range(63), $urandom_range(63),
                         1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        row_count_reg = SIZE_W'(MAX_ROWS);
        col_count_reg = SIZE_W'(MAX_COLS);
        gen_count     = '0;
        wipe_grid();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Full 64x64 grid from reset: corners wrap onto each other.
        push_cmd(FN_READ,   0,  0, 1'b0);    // cleared at reset
        push_cmd(FN_WRITE,  0,  0, 1'b1);
        push_cmd(FN_WRITE, 63, 63, 1'b1);
        push_cmd(FN_WRITE,  0, 63, 1'b1);
        push_cmd(FN_WRITE, 63,  0, 1'b1);
        push_cmd(FN_READ,   0,  0, 1'b0);    // three neighbors via wrap
        push_cmd(FN_READ,  63, 63, 1'b1);
        push_cmd(FN_READ,  62, 62, 1'b0);
        push_cmd(FN_EVOLVE, 0,  0, 1'b0);
        push_cmd(FN_READ,   0,  0, 1'b0);
        push_cmd(FN_WRITE,  0,  0, 1'b0);
        push_cmd(FN_READ,   0,  0, 1'b1);
        push_cmd(FN_CLEAR, 63, 63, 1'b1);    // cells die, generation kept
        push_cmd(FN_READ,  63, 63, 1'b0);

        // Zero rows acts as one, oversize columns cap at 64: a 1x64 ring.
        set_grid_size(SIZE_W'(0), SIZE_W'(127));
        push_cmd(FN_WRITE,  5,  3, 1'b1);    // row outside grid, dropped
        push_cmd(FN_READ,   5,  3, 1'b1);    // outside grid reads zero
        push_cmd(FN_WRITE,  0, 10, 1'b1);
        push_cmd(FN_READ,   0, 10, 1'b0);    // sees itself twice
        push_cmd(FN_EVOLVE, 0,  0, 1'b0);

        // Single cell: all eight neighbors are the cell itself.
        set_grid_size(SIZE_W'(1), SIZE_W'(1));
        push_cmd(FN_WRITE,  0,  0, 1'b1);
        push_cmd(FN_WRITE,  0,  1, 1'b1);    // column outside grid, dropped
        push_cmd(FN_READ,   0,  0, 1'b0);
        push_cmd(FN_EVOLVE, 0,  0, 1'b0);
        push_cmd(FN_READ,   0,  0, 1'b0);

        // Random part over a spread of sizes, small ones most of the time.
        random_phase(SIZE_W'(5),  SIZE_W'(7),  8);
        random_phase(SIZE_W'(1),  SIZE_W'(1),  6);
        random_phase(SIZE_W'(2),  SIZE_W'(3),  6);
        random_phase(SIZE_W'(64), SIZE_W'(1),  6);
        random_phase(SIZE_W'(1),  SIZE_W'(64), 6);
        random_phase(SIZE_W'(64), SIZE_W'(64), 8);
        random_phase(SIZE_W'($urandom_range(12, 1)), SIZE_W'($urandom_range(12, 1)), 6);
        random_phase(SIZE_W'($urandom_range(12, 1)), SIZE_W'($urandom_range(12, 1)), 6);

        // No idling on either side for a whole phase.
        wait_drained();
        steady_run = 1'b1;
        random_phase(SIZE_W'(16), SIZE_W'(16), 8);

        // Back-pressure: receiver holds off while the sender keeps offering,
        // so the output register fills and cmd.ready must drop.
        set_grid_size(SIZE_W'(8), SIZE_W'(8));
        stall_requests++;
        for (int k = 0; k < 16; k++)
        begin
            if (k % 3 == 2)
                push_cmd(FN_READ, $urandom_range(7), $urandom_range(7), 1'b0);
            else
                push_cmd(FN_WRITE, $urandom_range(7), $urandom_range(7),
                         1'($urandom_range(1)));
        end
        wait_drained();
        steady_run = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog on total run length.
    initial
    begin
        for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++)
            @(posedge clk);
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lge_pkg.sv
rtl/lge_cmd_if.sv
rtl/lge_rsp_if.sv
rtl/lge_apb_regs.sv
rtl/lge_grid_mem.sv
rtl/lge_nbr_unit.sv
rtl/life_generation_engine_core.sv
tb/testbench.sv
